// ----- rtl/pwcd_pkg.sv -----
`timescale 1ns / 1ps

package pwcd_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_CTRL   = 2'd1,
    MODE_IGNORE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_DTOL    = 2'd1,
    REG_CTOL    = 2'd2,
    REG_CONFIRM = 2'd3
  } reg_idx_e;

  localparam int unsigned MODE_RESET    = 0;
  localparam int unsigned DTOL_RESET    = 35;
  localparam int unsigned CTOL_RESET    = 2000;
  localparam int unsigned CONFIRM_RESET = 5;

  // direct grid: 100 us, rounded width 1100..4300
  localparam int unsigned DIRECT_GRID   = 100;
  localparam int unsigned DIRECT_HALF   = DIRECT_GRID / 2;
  localparam int unsigned DIRECT_LIMIT  = 4300 + DIRECT_HALF;
  localparam int unsigned DIRECT_Q_MIN  = 11;
  localparam int unsigned DIRECT_RECIP  = 1311;
  localparam int unsigned DIRECT_SHIFT  = 15;

  // controller grid: 10000 us, rounded width 10000..140000
  localparam int unsigned CTRL_GRID     = 10000;
  localparam int unsigned CTRL_HALF     = CTRL_GRID / 2;
  localparam int unsigned CTRL_LIMIT    = 140000 + CTRL_HALF;
  localparam int unsigned CTRL_Q_MIN    = 1;
  localparam int unsigned CTRL_RECIP    = 26844;
  localparam int unsigned CTRL_SHIFT    = 24;

  localparam int unsigned STEPS_PER_MOTOR = 11;
  localparam int unsigned RUN_MAX         = 255;
  localparam int unsigned NO_DIRECT_INDEX = 63;
  localparam int unsigned NO_CTRL_INDEX   = 15;
  localparam int unsigned NO_MOTOR        = 3;
  localparam int unsigned NO_STEP_CODE    = 32;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  dtol;
    logic [12:0] ctol;
    logic [7:0]  confirm;
  } cfg_t;

  typedef struct packed {
    logic       ctrl;
    logic       ok;
    logic [5:0] idx;
  } item_t;

  function automatic logic signed [5:0] step_code(input logic [3:0] sel);
    logic signed [5:0] code;
    case (sel)
      4'd0:    code = -6'sd16;
      4'd1:    code = -6'sd8;
      4'd2:    code = -6'sd4;
      4'd3:    code = -6'sd2;
      4'd4:    code = -6'sd1;
      4'd5:    code = 6'sd0;
      4'd6:    code = 6'sd1;
      4'd7:    code = 6'sd2;
      4'd8:    code = 6'sd4;
      4'd9:    code = 6'sd8;
      4'd10:   code = 6'sd16;
      default: code = 6'sd0;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/pwcd_pulse_if.sv -----
`timescale 1ns / 1ps

interface pwcd_pulse_if #(
  parameter int unsigned PULSE_WIDTH_BITS = 18
) ();
  logic                        valid;
  logic                        ready;
  logic [PULSE_WIDTH_BITS-1:0] pulse_width_us;

  modport source (output valid, output pulse_width_us, input ready);
  modport sink (input valid, input pulse_width_us, output ready);
endinterface

// ----- rtl/pwcd_cmd_if.sv -----
`timescale 1ns / 1ps

interface pwcd_cmd_if ();
  logic              valid;
  logic              ready;
  logic [1:0]        motor_id;
  logic signed [5:0] step_amount;

  modport source (output valid, output motor_id, output step_amount, input ready);
  modport sink (input valid, input motor_id, input step_amount, output ready);
endinterface

// ----- rtl/pwm_width_command_decoder_core.sv -----
`timescale 1ns / 1ps

// channel   | dir | handshake       | payload
// pulse_in  | in  | valid/ready     | pulse_width_us [PULSE_WIDTH_BITS-1:0]
// cmd_out   | out | valid/ready     | motor_id [1:0], step_amount signed [5:0]
// apb       | in  | psel/penable    | paddr [3:0], pwdata/prdata [31:0]
//
// one pulse per cycle sustained while cmd_out is ready; pulse_in passes the
// front divide-and-check stage, the transaction queue and output register
// reset loads the register defaults and clears all run filters
// a stalled output fills the two-entry queue, then the front, then pulse_in

module pwm_width_command_decoder_core #(
  parameter int unsigned PULSE_WIDTH_BITS = 18
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pwcd_pulse_if.sink                      pulse_in,
  pwcd_cmd_if.source                      cmd_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pwcd_pkg::ADDR_W-1:0]     paddr,
  input  logic [pwcd_pkg::DATA_W-1:0]     pwdata,
  output logic [pwcd_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import pwcd_pkg::*;

  logic [1:0]  mode_q, mode_d;
  logic [5:0]  dtol_q, dtol_d;
  logic [12:0] ctol_q, ctol_d;
  logic [7:0]  confirm_q, confirm_d;
  logic        wr_en;
  logic        clear;
  logic [1:0]  reg_idx;
  cfg_t        cfg;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;
  item_t       push_item;
  item_t       head_item;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign clear   = wr_en && (reg_idx == REG_MODE);

  always_comb begin
    mode_d    = mode_q;
    dtol_d    = dtol_q;
    ctol_d    = ctol_q;
    confirm_d = confirm_q;
    if (wr_en) begin
      case (reg_idx)
        REG_MODE:    mode_d    = pwdata[1:0];
        REG_DTOL:    dtol_d    = pwdata[5:0];
        REG_CTOL:    ctol_d    = pwdata[12:0];
        REG_CONFIRM: confirm_d = pwdata[7:0];
        default:     mode_d    = mode_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:    prdata = DATA_W'(mode_q);
      REG_DTOL:    prdata = DATA_W'(dtol_q);
      REG_CTOL:    prdata = DATA_W'(ctol_q);
      REG_CONFIRM: prdata = DATA_W'(confirm_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 2'(MODE_RESET);
      dtol_q    <= 6'(DTOL_RESET);
      ctol_q    <= 13'(CTOL_RESET);
      confirm_q <= 8'(CONFIRM_RESET);
    end else begin
      mode_q    <= mode_d;
      dtol_q    <= dtol_d;
      ctol_q    <= ctol_d;
      confirm_q <= confirm_d;
    end
  end

  assign cfg.mode    = mode_q;
  assign cfg.dtol    = dtol_q;
  assign cfg.ctol    = ctol_q;
  assign cfg.confirm = confirm_q;

  pwcd_front #(
    .PULSE_WIDTH_BITS(PULSE_WIDTH_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pulse_in (pulse_in),
    .cfg_i    (cfg),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (push_item)
  );

  pwcd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .item_o  (head_item)
  );

  pwcd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .confirm_i (cfg.confirm),
    .clear_i   (clear),
    .empty_i   (q_empty),
    .item_i    (head_item),
    .pop_o     (pop),
    .cmd_out   (cmd_out)
  );

endmodule

// ----- rtl/pwcd_front.sv -----
`timescale 1ns / 1ps

module pwcd_front #(
  parameter int unsigned PULSE_WIDTH_BITS = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pwcd_pulse_if.sink      pulse_in,
  input  pwcd_pkg::cfg_t  cfg_i,
  input  logic            q_full_i,
  output logic            push_o,
  output pwcd_pkg::item_t item_o
);
  import pwcd_pkg::*;

  logic [PULSE_WIDTH_BITS-1:0] width;
  logic [32:0] w_ext;
  logic        take;
  logic        keep;
  logic        adv;

  logic [12:0] n_d;
  logic [10:0] m_d;
  logic [25:0] prod_d;
  logic [17:0] n_c;
  logic [13:0] m_c;
  logic [28:0] prod_c;
  logic        range_d;
  logic        range_c;

  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_mode_q, s1_mode_d;
  logic [5:0]  s1_quo_q, s1_quo_d;
  logic [17:0] s1_w_q, s1_w_d;
  logic        s1_range_q, s1_range_d;

  logic [12:0] rnd_d;
  logic [12:0] diff_d;
  logic [17:0] rnd_c;
  logic [17:0] diff_c;
  logic        ok_d;
  logic        ok_c;

  assign width = pulse_in.pulse_width_us;
  assign w_ext = 33'(width);

  // quotient by reciprocal multiply
  assign range_d = w_ext < 33'(DIRECT_LIMIT);
  assign n_d     = w_ext[12:0] + 13'(DIRECT_HALF);
  assign m_d     = n_d[12:2];
  assign prod_d  = 26'(m_d) * 26'(DIRECT_RECIP);

  assign range_c = w_ext < 33'(CTRL_LIMIT);
  assign n_c     = w_ext[17:0] + 18'(CTRL_HALF);
  assign m_c     = n_c[17:4];
  assign prod_c  = 29'(m_c) * 29'(CTRL_RECIP);

  assign keep = (s1_mode_q == MODE_DIRECT) || (s1_mode_q == MODE_CTRL);
  assign adv  = !s1_valid_q || !keep || !q_full_i;
  assign pulse_in.ready = adv;
  assign take = pulse_in.valid && adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_mode_d  = s1_mode_q;
    s1_quo_d   = s1_quo_q;
    s1_w_d     = s1_w_q;
    s1_range_d = s1_range_q;
    if (adv) begin
      s1_valid_d = take;
    end
    if (take) begin
      s1_mode_d = cfg_i.mode;
      s1_w_d    = w_ext[17:0];
      if (cfg_i.mode == MODE_CTRL) begin
        s1_quo_d   = 6'(prod_c >> CTRL_SHIFT);
        s1_range_d = range_c;
      end else begin
        s1_quo_d   = 6'(prod_d >> DIRECT_SHIFT);
        s1_range_d = range_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q  <= s1_mode_d;
    s1_quo_q   <= s1_quo_d;
    s1_w_q     <= s1_w_d;
    s1_range_q <= s1_range_d;
  end

  // grid check against the rounded width
  assign rnd_d  = 13'(s1_quo_q) * 13'(DIRECT_GRID);
  assign diff_d = (s1_w_q[12:0] > rnd_d) ? (s1_w_q[12:0] - rnd_d) : (rnd_d - s1_w_q[12:0]);
  assign ok_d   = s1_range_q && (s1_quo_q >= 6'(DIRECT_Q_MIN)) && (diff_d <= 13'(cfg_i.dtol));

  assign rnd_c  = 18'(s1_quo_q[3:0]) * 18'(CTRL_GRID);
  assign diff_c = (s1_w_q > rnd_c) ? (s1_w_q - rnd_c) : (rnd_c - s1_w_q);
  assign ok_c   = s1_range_q && (s1_quo_q[3:0] >= 4'(CTRL_Q_MIN))
               && (diff_c <= 18'(cfg_i.ctol));

  always_comb begin
    item_o.ctrl = (s1_mode_q == MODE_CTRL);
    if (s1_mode_q == MODE_CTRL) begin
      item_o.ok  = ok_c;
      item_o.idx = 6'(s1_quo_q[3:0] - 4'(CTRL_Q_MIN));
    end else begin
      item_o.ok  = ok_d;
      item_o.idx = s1_quo_q - 6'(DIRECT_Q_MIN);
    end
  end

  assign push_o = s1_valid_q && keep && !q_full_i;

endmodule

// ----- rtl/pwcd_queue.sv -----
`timescale 1ns / 1ps

module pwcd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pwcd_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output pwcd_pkg::item_t item_o
);
  import pwcd_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/pwcd_back.sv -----
`timescale 1ns / 1ps

module pwcd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      confirm_i,
  input  logic            clear_i,
  input  logic            empty_i,
  input  pwcd_pkg::item_t item_i,
  output logic            pop_o,
  pwcd_cmd_if.source      cmd_out
);
  import pwcd_pkg::*;

  logic [5:0] d_run_idx_q, d_run_idx_d;
  logic [7:0] d_run_cnt_q, d_run_cnt_d;
  logic [5:0] d_done_idx_q, d_done_idx_d;
  logic [3:0] c_run_idx_q, c_run_idx_d;
  logic [7:0] c_run_cnt_q, c_run_cnt_d;
  logic [1:0] c_done_motor_q, c_done_motor_d;
  logic [5:0] c_done_step_q, c_done_step_d;
  logic [1:0] sel_motor_q, sel_motor_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_motor_q, out_motor_d;
  logic signed [5:0] out_step_q, out_step_d;

  logic              emit;
  logic [1:0]        emit_motor;
  logic signed [5:0] emit_step;
  logic [1:0]        d_motor;
  logic [3:0]        d_rem;
  logic [3:0]        c_idx;
  logic signed [5:0] c_code;

  assign pop_o = !empty_i && (!out_valid_q || cmd_out.ready);
  assign c_idx = item_i.idx[3:0];
  assign c_code = step_code(c_idx);

  always_comb begin
    if (item_i.idx >= 6'(2 * STEPS_PER_MOTOR)) begin
      d_motor = 2'd2;
      d_rem   = 4'(item_i.idx - 6'(2 * STEPS_PER_MOTOR));
    end else if (item_i.idx >= 6'(STEPS_PER_MOTOR)) begin
      d_motor = 2'd1;
      d_rem   = 4'(item_i.idx - 6'(STEPS_PER_MOTOR));
    end else begin
      d_motor = 2'd0;
      d_rem   = item_i.idx[3:0];
    end
  end

  always_comb begin
    d_run_idx_d    = d_run_idx_q;
    d_run_cnt_d    = d_run_cnt_q;
    d_done_idx_d   = d_done_idx_q;
    c_run_idx_d    = c_run_idx_q;
    c_run_cnt_d    = c_run_cnt_q;
    c_done_motor_d = c_done_motor_q;
    c_done_step_d  = c_done_step_q;
    sel_motor_d    = sel_motor_q;
    emit           = 1'b0;
    emit_motor     = d_motor;
    emit_step      = step_code(d_rem);
    if (clear_i) begin
      d_run_idx_d    = 6'(NO_DIRECT_INDEX);
      d_run_cnt_d    = '0;
      d_done_idx_d   = 6'(NO_DIRECT_INDEX);
      c_run_idx_d    = 4'(NO_CTRL_INDEX);
      c_run_cnt_d    = '0;
      c_done_motor_d = 2'(NO_MOTOR);
      c_done_step_d  = 6'(NO_STEP_CODE);
    end else if (pop_o) begin
      if (!item_i.ctrl) begin
        if (!item_i.ok) begin
          d_run_idx_d = 6'(NO_DIRECT_INDEX);
          d_run_cnt_d = '0;
        end else begin
          if (item_i.idx == d_run_idx_q) begin
            if (d_run_cnt_q != 8'(RUN_MAX)) begin
              d_run_cnt_d = d_run_cnt_q + 1'b1;
            end
          end else begin
            d_run_idx_d = item_i.idx;
            d_run_cnt_d = 8'd1;
          end
          if ((d_run_cnt_d >= confirm_i) && (item_i.idx != d_done_idx_q)) begin
            d_done_idx_d = item_i.idx;
            emit         = 1'b1;
          end
        end
      end else begin
        emit_motor = sel_motor_q;
        emit_step  = c_code;
        if (!item_i.ok) begin
          c_run_idx_d = 4'(NO_CTRL_INDEX);
          c_run_cnt_d = '0;
        end else begin
          if (c_idx == c_run_idx_q) begin
            if (c_run_cnt_q != 8'(RUN_MAX)) begin
              c_run_cnt_d = c_run_cnt_q + 1'b1;
            end
          end else begin
            c_run_idx_d = c_idx;
            c_run_cnt_d = 8'd1;
          end
          if (c_run_cnt_d == confirm_i) begin
            if (c_idx >= 4'(STEPS_PER_MOTOR)) begin
              sel_motor_d = 2'(c_idx - 4'(STEPS_PER_MOTOR));
            end else if ((sel_motor_q != 2'(NO_MOTOR))
                         && ((sel_motor_q != c_done_motor_q)
                             || (c_code != c_done_step_q))) begin
              c_done_motor_d = sel_motor_q;
              c_done_step_d  = c_code;
              emit           = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_motor_d = out_motor_q;
    out_step_d  = out_step_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_motor_d = emit_motor;
      out_step_d  = emit_step;
    end else if (cmd_out.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_run_idx_q    <= 6'(NO_DIRECT_INDEX);
      d_run_cnt_q    <= '0;
      d_done_idx_q   <= 6'(NO_DIRECT_INDEX);
      c_run_idx_q    <= 4'(NO_CTRL_INDEX);
      c_run_cnt_q    <= '0;
      c_done_motor_q <= 2'(NO_MOTOR);
      c_done_step_q  <= 6'(NO_STEP_CODE);
      sel_motor_q    <= 2'(NO_MOTOR);
      out_valid_q    <= 1'b0;
    end else begin
      d_run_idx_q    <= d_run_idx_d;
      d_run_cnt_q    <= d_run_cnt_d;
      d_done_idx_q   <= d_done_idx_d;
      c_run_idx_q    <= c_run_idx_d;
      c_run_cnt_q    <= c_run_cnt_d;
      c_done_motor_q <= c_done_motor_d;
      c_done_step_q  <= c_done_step_d;
      sel_motor_q    <= sel_motor_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_motor_q <= out_motor_d;
    out_step_q  <= out_step_d;
  end

  assign cmd_out.valid       = out_valid_q;
  assign cmd_out.motor_id    = out_motor_q;
  assign cmd_out.step_amount = out_step_q;

endmodule
